// File: design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes for the periodic timer table
// Command codes, result kinds, the command and result words, and the probe
// and fire words that travel between the top level and the slot cells.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // command codes; code 3 is unused and ignored
    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    // result kinds
    localparam logic KIND_CREATE = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned OWNER_W = 16;
    localparam int unsigned TIME_W  = 32;

    // one command word
    typedef struct packed {
        logic [1:0]         cmd;
        logic [OWNER_W-1:0] owner_id;
        logic [TIME_W-1:0]  period_ms;
        logic [ID_W-1:0]    cancel_id;
        logic [TIME_W-1:0]  now_ms;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    timer_number;
        logic [OWNER_W-1:0] owner_app;
        logic               last;
    } t_out_word;

    // command probe handed from cell to cell;
    // key is the new id (create), the id to cancel, or the current time (tick)
    typedef struct packed {
        logic               valid;
        logic [1:0]         cmd;
        logic               taken;
        logic [OWNER_W-1:0] owner;
        logic [TIME_W-1:0]  period;
        logic [ID_W-1:0]    key;
    } t_probe;

    // expiry report of one cell
    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [OWNER_W-1:0] owner;
    } t_fire;

endpackage

// File: design/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_timer_table: table of periodic timers
// A row of slot cells; each command word walks the row one cell per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word on i_cmd_word is taken at a rising edge with
//   start high and busy low. Commands: create (owner, period), cancel (id),
//   tick (current time); code 3 is ignored.
//   Result channel: each result word sits on o_result_word for one cycle
//   with o_strobe high. The receiver cannot stall this channel.
//   Create gives one reply (new id, 0 if the table is full). Cancel gives
//   nothing. Tick gives one expiry word per firing slot in slot order, the
//   final one with last set; a tick where nothing fires gives nothing.
//   Timing: the command walks the row of NUM_TIMERS cells, one cell a
//   cycle, between the launch register and the result register. Busy
//   drops in the same cycle as the final result strobes, and no new
//   command is taken until then. Expiry words appear as the command
//   reaches each firing cell, each one held back until the next is known.
//   Reset: all slots inactive, next id 1, no command in flight.
// ----------------------------------------------------------------------------
module periodic_timer_table import ptt_pkg::*; #(
    parameter int unsigned NUM_TIMERS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd_word,
    output logic      o_strobe,
    output t_out_word o_result_word
);

    t_probe             chain [NUM_TIMERS+1];
    t_fire              fires [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] fire_vec;

    logic               r_busy;
    t_probe             r_probe;
    logic [ID_W-1:0]    r_next_id;
    logic               r_pend_valid;
    logic [ID_W-1:0]    r_pend_id;
    logic [OWNER_W-1:0] r_pend_owner;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               n_busy;
    t_probe             n_probe;
    logic [ID_W-1:0]    n_next_id;
    logic               n_pend_valid;
    logic [ID_W-1:0]    n_pend_id;
    logic [OWNER_W-1:0] n_pend_owner;
    logic               n_out_valid;
    t_out_word          n_out;

    logic               accept;
    logic               fire_any;
    logic [ID_W-1:0]    fire_id;
    logic [OWNER_W-1:0] fire_owner;
    t_probe             tail;

    assign accept   = start && !r_busy;
    assign chain[0] = r_probe;
    assign tail     = chain[NUM_TIMERS];

    // row of slot cells
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        ptt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (chain[g]),
            .o_probe (chain[g+1]),
            .o_fire  (fires[g])
        );
        assign fire_vec[g] = fires[g].valid;
    end

    // at most one cell holds the probe, so an OR picks its report
    always_comb begin
        fire_any   = 1'b0;
        fire_id    = '0;
        fire_owner = '0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            fire_any   = fire_any | fires[k].valid;
            fire_id    = fire_id | ({ID_W{fires[k].valid}} & fires[k].id);
            fire_owner = fire_owner | ({OWNER_W{fires[k].valid}} & fires[k].owner);
        end
    end

    // command launch, result sequencing
    always_comb begin
        n_busy       = r_busy;
        n_probe      = r_probe;
        n_next_id    = r_next_id;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_owner = r_pend_owner;
        n_out_valid  = 1'b0;
        n_out        = r_out;

        // launch into the first cell
        n_probe.valid = 1'b0;
        if (accept) begin
            n_busy         = 1'b1;
            n_probe.valid  = 1'b1;
            n_probe.cmd    = i_cmd_word.cmd;
            n_probe.taken  = 1'b0;
            n_probe.owner  = i_cmd_word.owner_id;
            n_probe.period = i_cmd_word.period_ms;
            case (i_cmd_word.cmd)
                CMD_CREATE: n_probe.key = r_next_id;
                CMD_CANCEL: n_probe.key = i_cmd_word.cancel_id;
                default:    n_probe.key = i_cmd_word.now_ms;
            endcase
        end

        // expiry: release the held word, hold the new one
        if (fire_any) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out       = '{kind: KIND_EXPIRY, timer_number: r_pend_id,
                                owner_app: r_pend_owner, last: 1'b0};
            end
            n_pend_valid = 1'b1;
            n_pend_id    = fire_id;
            n_pend_owner = fire_owner;
        end

        // probe leaves the row: final word
        if (tail.valid) begin
            n_busy = 1'b0;
            if (tail.cmd == CMD_CREATE) begin
                n_out_valid = 1'b1;
                n_out       = '{kind: KIND_CREATE,
                                timer_number: tail.taken ? tail.key : '0,
                                owner_app: '0, last: 1'b1};
                if (tail.taken) begin
                    n_next_id = r_next_id + 1'b1;
                end
            end else if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out        = '{kind: KIND_EXPIRY, timer_number: r_pend_id,
                                 owner_app: r_pend_owner, last: 1'b1};
                n_pend_valid = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_probe      <= '0;
            r_next_id    <= ID_W'(1);
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_probe      <= n_probe;
            r_next_id    <= n_next_id;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        r_pend_id    <= n_pend_id;
        r_pend_owner <= n_pend_owner;
        r_out        <= n_out;
    end

    assign busy          = r_busy;
    assign o_strobe      = r_out_valid;
    assign o_result_word = r_out;

    // checks
    a_one_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(fire_vec))
        else $error("more than one cell fired in a cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (!r_pend_valid && !r_probe.valid && !tail.valid))
        else $error("work left over while idle");

    a_create_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result_word.kind == KIND_CREATE)) |-> o_result_word.last)
        else $error("create reply without last");

    a_last_drops_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_word.last) |-> !busy)
        else $error("final result while still busy");

endmodule

// File: design/ptt_cell.sv
// ----------------------------------------------------------------------------
// ptt_cell: one timer slot of the table
// Holds the slot state, acts on the probe passing by, and hands the probe
// on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module ptt_cell import ptt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_probe i_probe,
    output t_probe o_probe,
    output t_fire  o_fire
);

    logic               r_active;
    logic [ID_W-1:0]    r_id;
    logic [OWNER_W-1:0] r_owner;
    logic [TIME_W-1:0]  r_period;
    logic [TIME_W-1:0]  r_last_fire;
    t_probe             r_probe;

    t_probe             n_probe;
    logic [TIME_W-1:0]  elapsed;
    logic               create_hit;
    logic               cancel_hit;
    logic               fire_hit;

    // slot decisions for the probe now at this cell
    always_comb begin
        elapsed    = i_probe.key - r_last_fire;
        create_hit = i_probe.valid && (i_probe.cmd == CMD_CREATE) &&
                     !i_probe.taken && !r_active;
        cancel_hit = i_probe.valid && (i_probe.cmd == CMD_CANCEL) &&
                     !i_probe.taken && r_active && (r_id == i_probe.key);
        fire_hit   = i_probe.valid && (i_probe.cmd == CMD_TICK) &&
                     r_active && (elapsed >= r_period);
        n_probe       = i_probe;
        n_probe.taken = i_probe.taken || create_hit || cancel_hit;
    end

    assign o_fire.valid = fire_hit;
    assign o_fire.id    = r_id;
    assign o_fire.owner = r_owner;
    assign o_probe      = r_probe;

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_id     <= '0;
        end else if (create_hit) begin
            r_active <= 1'b1;
            r_id     <= i_probe.key;
        end else if (cancel_hit) begin
            r_active <= 1'b0;
        end
    end

    // slot payload, no reset
    always_ff @(posedge i_clk) begin
        if (create_hit) begin
            r_owner     <= i_probe.owner;
            r_period    <= i_probe.period;
            r_last_fire <= '0;
        end else if (fire_hit) begin
            r_last_fire <= i_probe.key;
        end
    end

    // probe stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

endmodule
